@@ rtl/core/hso_pkg.sv @@
// Shared types and constants for the Horn-Schunck optical flow engine.
// Holds the request/response/config structs, controller state and datapath commands.
// No dependencies.
package hso_pkg;

   localparam int PIX_W   = 8;
   localparam int GRAD_W  = 12;
   localparam int FLOW_W  = 20;
   localparam int SUM_W   = 24;
   localparam int MA_W    = 13;
   localparam int NSUM_W  = 32;
   localparam int PROD_W  = 45;
   localparam int DEN_W   = 25;
   localparam int QUOT_W  = PROD_W + 1;
   localparam int EXT_W   = QUOT_W + 1;
   localparam int DCNT_W  = 6;

   localparam int FLOW_MAX    = 524287;
   localparam int FLOW_MIN    = -524288;
   localparam int AVG_DIVISOR = 12;
   localparam int T_SHIFT     = 10;

   // ceil(2^27 / 12); floor(m * AVG_RECIP >> 27) == m / 12 for m below 2^23
   localparam int               AVG_SHIFT  = 27;
   localparam int               AVG_PROD_W = 2 * SUM_W;
   localparam logic [SUM_W-1:0] AVG_RECIP  = 24'd11184811;

   localparam logic [1:0] OP_LOAD    = 2'd0;
   localparam logic [1:0] OP_COMPUTE = 2'd1;
   localparam logic [1:0] OP_READ    = 2'd2;

   localparam logic [1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [1:0] CSR_ITER_COUNT   = 2'd2;
   localparam logic [1:0] CSR_ALPHA        = 2'd3;

   localparam logic RSP_DONE = 1'b0;
   localparam logic RSP_FLOW = 1'b1;

   localparam logic [2:0] TAP_FIRST  = 3'd0;
   localparam logic [2:0] TAP_G_LAST = 3'd3;
   localparam logic [2:0] TAP_J_LAST = 3'd7;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] pixel_index;
      logic [7:0]  sample_first;
      logic [7:0]  sample_second;
   } req_type;

   typedef struct packed {
      logic                     result_kind;
      logic signed [FLOW_W-1:0] flow_u;
      logic signed [FLOW_W-1:0] flow_v;
   } rsp_type;

   typedef struct packed {
      logic [8:0]  frame_width;
      logic [8:0]  frame_height;
      logic [9:0]  iteration_count;
      logic [11:0] smoothness_alpha;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_RD_DONE, ST_G_TAP, ST_G_WAIT, ST_G_WR, ST_J_TAP, ST_J_WAIT,
      ST_BU_DIV, ST_BU_WAIT, ST_BV_DIV, ST_BV_WAIT, ST_M_AA, ST_M_XX, ST_M_YY,
      ST_M_XU, ST_M_YV, ST_N_SUM, ST_M_XN, ST_U_DIV, ST_U_WAIT, ST_M_YN,
      ST_V_DIV, ST_V_WAIT, ST_J_WR, ST_DONE
   } ctrl_state_type;

   typedef enum logic [4:0] {
      DP_NONE, DP_LOAD, DP_RD_ISSUE, DP_RD_DONE, DP_START, DP_G_TAP, DP_G_WR,
      DP_J_TAP, DP_BU_DIV, DP_BU_CAP, DP_BV_DIV, DP_BV_CAP, DP_M_AA, DP_M_XX,
      DP_M_YY, DP_M_XU, DP_M_YV, DP_N_SUM, DP_M_XN, DP_U_DIV, DP_U_CAP, DP_M_YN,
      DP_V_DIV, DP_V_CAP, DP_J_WR, DP_FINISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [2:0] tap;
   } dp_cmd_type;

   typedef struct packed {
      logic rsp_full;
      logic div_done;
      logic last_pix;
      logic last_iter;
      logic no_iter;
   } dp_status_type;

endpackage

@@ rtl/core/horn_schunck_optical_flow.sv @@
// Horn-Schunck optical flow engine, top level.
// Request channel (req_*): op 0 loads a pixel pair of both frames at pixel_index,
// op 1 computes flow over the configured frame, op 2 reads the flow at pixel_index.
// Response channel (rsp_*): one response for op 1 (result_kind 0, flow zero) and
// one for op 2 (result_kind 1 with the flow); op 0 and op 3 give none.
// Loads stream back to back while the engine is idle, also while a response waits.
// A read is issued on acceptance and answered from ST_RD_DONE; the next read is
// taken once the response register is free.
// A compute sweeps w*h pixels once for derivatives, then runs iteration_count
// passes of w*h pixels. Each pixel of a pass takes 8 neighbour reads, two
// reciprocal-multiply averages, 7 multiplies and two serial divides on the
// shared divider, which set the pace. Configuration (csr_*) is written through
// a plain write port, by the user only while idle; the block does not enforce it.
// Reset is synchronous: it clears control, empties the response register and
// makes all flow reads return zero until a compute with nonzero iterations.
// Frame and gradient stores need no clearing. When rsp_stall is high the
// response holds and read/compute requests are stalled.
// Depends on hso_pkg, hso_ctrl, hso_dp, hso_div.
module horn_schunck_optical_flow import hso_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [11:0] csr_wr_data
);

   cfg_type       cfg_ff;
   dp_cmd_type    cmd;
   dp_status_type status;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width      <= 9'd256;
         cfg_ff.frame_height     <= 9'd256;
         cfg_ff.iteration_count  <= 10'd64;
         cfg_ff.smoothness_alpha <= 12'd40;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_FRAME_WIDTH:  cfg_ff.frame_width      <= csr_wr_data[8:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height     <= csr_wr_data[8:0];
            CSR_ITER_COUNT:   cfg_ff.iteration_count  <= csr_wr_data[9:0];
            CSR_ALPHA:        cfg_ff.smoothness_alpha <= csr_wr_data;
            default: ;
         endcase
      end
   end

   hso_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_data.op),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   hso_dp #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req       (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

@@ rtl/core/hso_div.sv @@
// Bit-serial divider, rounds to nearest with ties away from zero.
// Signed numerator, positive divisor, one quotient bit per cycle. Uses hso_pkg.
module hso_div import hso_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [PROD_W-1:0] num,
   input  logic [DEN_W-1:0]         den,
   output logic                     done,
   output logic signed [QUOT_W-1:0] quot
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [PROD_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              neg_ff, neg_in;
   logic [PROD_W-1:0] mag;
   logic [DEN_W:0]    trial;
   logic              qbit;

   always_comb begin
      mag     = (num < 0) ? PROD_W'(-num) : PROD_W'(num);
      mag     = mag + PROD_W'(den >> 1);
      trial   = {rem_ff, quo_ff[PROD_W-1]};
      qbit    = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = DCNT_W'(PROD_W);
         rem_in  = '0;
         quo_in  = mag;
         den_in  = den;
         neg_in  = num < 0;
      end else if (busy_ff) begin
         rem_in = qbit ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[PROD_W-2:0], qbit};
         cnt_in = cnt_ff - DCNT_W'(1);
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quot = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

@@ rtl/core/hso_dp.sv @@
// Datapath: frame, gradient and flow stores, address walk, multiplier and result register.
// Driven by hso_ctrl through dp_cmd_type; uses hso_pkg and hso_div.
module hso_dp import hso_pkg::*; #(
   parameter int MAX_WIDTH  = 256,
   parameter int MAX_HEIGHT = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  cfg_type       cfg,
   input  req_type       req,
   input  dp_cmd_type    cmd,
   output dp_status_type status,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output rsp_type       rsp_data
);

   localparam int PIX = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW  = $clog2(PIX);
   localparam int WW  = $clog2(MAX_WIDTH + 1);
   localparam int HW  = $clog2(MAX_HEIGHT + 1);
   localparam int CW  = $clog2(PIX + 1);

   function automatic logic signed [FLOW_W-1:0] sat_flow(input logic signed [EXT_W-1:0] x);
      if (x > EXT_W'(FLOW_MAX)) return FLOW_W'(FLOW_MAX);
      if (x < EXT_W'(FLOW_MIN)) return FLOW_W'(FLOW_MIN);
      return FLOW_W'(x);
   endfunction

   logic [PIX_W-1:0]         fa_mem [PIX];
   logic [PIX_W-1:0]         fb_mem [PIX];
   logic signed [GRAD_W-1:0] gx_mem [PIX];
   logic signed [GRAD_W-1:0] gy_mem [PIX];
   logic signed [GRAD_W-1:0] gt_mem [PIX];
   logic signed [FLOW_W-1:0] fu_mem [2*PIX];
   logic signed [FLOW_W-1:0] fv_mem [2*PIX];

   logic [PIX_W-1:0]         fa_q, fb_q;
   logic signed [GRAD_W-1:0] gx_q, gy_q, gt_q;
   logic signed [FLOW_W-1:0] fu_q, fv_q;

   logic [WW-1:0] cur_w, w_ff;
   logic [HW-1:0] cur_h, h_ff;
   logic [CW-1:0] cur_count, flow_count_ff;
   logic [WW-1:0] i_ff;
   logic [HW-1:0] j_ff;
   logic [AW-1:0] k_ff;
   logic          bank_ff, first_ff;
   logic [9:0]    iter_ff, iter_total_ff;
   logic [11:0]   alpha_ff;
   dp_op_type     prev_op_ff;
   logic [2:0]    prev_tap_ff;
   logic          rd_hit_ff;
   logic          rsp_valid_ff;
   rsp_type       rsp_ff;

   logic [31:0]   idx32;
   logic [AW-1:0] idx_addr, nb_addr, x_off, y_off;
   logic [AW:0]   f_rd_addr;
   logic          load_ok, at_right, at_bottom;
   logic          neg_x, pos_x, neg_y, pos_y;

   logic signed [GRAD_W-1:0] gx_acc_ff, gy_acc_ff, gt_acc_ff, gx_ff, gy_ff, gt_ff;
   logic signed [GRAD_W-1:0] g_sum, g_dif, cx, cy;
   logic signed [SUM_W-1:0]  su_ff, sv_ff, cu, cv;
   logic signed [FLOW_W-1:0] fu_val, fv_val, bu_ff, bv_ff, nu_ff, nv_ff;
   logic signed [MA_W-1:0]   m_a;
   logic signed [NSUM_W-1:0] m_b, nsum_ff;
   logic signed [PROD_W-1:0] prod_ff, div_num;
   logic [DEN_W-1:0]         den_ff, div_den;
   logic                     div_start, div_done, den_zero;
   logic signed [QUOT_W-1:0] div_quot;
   logic [SUM_W-1:0]         avg_src, avg_mag;
   logic [AVG_PROD_W-1:0]    avg_prod_ff;
   logic                     avg_neg_ff;
   logic [FLOW_W:0]          avg_q;

   always_comb begin
      if (cfg.frame_width == '0) cur_w = WW'(1);
      else if (32'(cfg.frame_width) > MAX_WIDTH) cur_w = WW'(MAX_WIDTH);
      else cur_w = WW'(cfg.frame_width);
      if (cfg.frame_height == '0) cur_h = HW'(1);
      else if (32'(cfg.frame_height) > MAX_HEIGHT) cur_h = HW'(MAX_HEIGHT);
      else cur_h = HW'(cfg.frame_height);
      cur_count = CW'(cur_w) * CW'(cur_h);
   end

   assign idx32     = 32'(req.pixel_index);
   assign idx_addr  = idx32[AW-1:0];
   assign load_ok   = idx32 < 32'(PIX);
   assign at_right  = i_ff == w_ff - WW'(1);
   assign at_bottom = j_ff == h_ff - HW'(1);

   always_comb begin
      neg_x = 1'b0;
      pos_x = 1'b0;
      neg_y = 1'b0;
      pos_y = 1'b0;
      if (cmd.op == DP_G_TAP) begin
         pos_x = cmd.tap[0];
         pos_y = cmd.tap[1];
      end else begin
         case (cmd.tap)
            3'd0: neg_x = 1'b1;
            3'd1: pos_x = 1'b1;
            3'd2: neg_y = 1'b1;
            3'd3: pos_y = 1'b1;
            3'd4: begin neg_x = 1'b1; neg_y = 1'b1; end
            3'd5: begin pos_x = 1'b1; neg_y = 1'b1; end
            3'd6: begin neg_x = 1'b1; pos_y = 1'b1; end
            3'd7: begin pos_x = 1'b1; pos_y = 1'b1; end
            default: ;
         endcase
      end
      x_off = '0;
      if (neg_x && i_ff != '0) x_off = '1;
      else if (pos_x && !at_right) x_off = AW'(1);
      y_off = '0;
      if (neg_y && j_ff != '0) y_off = AW'(0) - AW'(w_ff);
      else if (pos_y && !at_bottom) y_off = AW'(w_ff);
      nb_addr   = k_ff + x_off + y_off;
      f_rd_addr = (cmd.op == DP_RD_ISSUE) ? {bank_ff, idx_addr} : {bank_ff, nb_addr};
   end

   // stores
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD && load_ok) begin
         fa_mem[idx_addr] <= req.sample_first;
         fb_mem[idx_addr] <= req.sample_second;
      end
      fa_q <= fa_mem[nb_addr];
      fb_q <= fb_mem[nb_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_G_WR) begin
         gx_mem[k_ff] <= gx_acc_ff;
         gy_mem[k_ff] <= gy_acc_ff;
         gt_mem[k_ff] <= gt_acc_ff;
      end
      gx_q <= gx_mem[k_ff];
      gy_q <= gy_mem[k_ff];
      gt_q <= gt_mem[k_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_J_WR) begin
         fu_mem[{~bank_ff, k_ff}] <= nu_ff;
         fv_mem[{~bank_ff, k_ff}] <= nv_ff;
      end
      fu_q <= fu_mem[f_rd_addr];
      fv_q <= fv_mem[f_rd_addr];
   end

   // tap accumulation, in the cycle after the read issue
   always_comb begin
      g_sum  = $signed(GRAD_W'(fa_q)) + $signed(GRAD_W'(fb_q));
      g_dif  = $signed(GRAD_W'(fb_q)) - $signed(GRAD_W'(fa_q));
      cx     = prev_tap_ff[0] ? g_sum : -g_sum;
      cy     = prev_tap_ff[1] ? g_sum : -g_sum;
      fu_val = first_ff ? '0 : fu_q;
      fv_val = first_ff ? '0 : fv_q;
      cu     = prev_tap_ff[2] ? SUM_W'(fu_val) : (SUM_W'(fu_val) <<< 1);
      cv     = prev_tap_ff[2] ? SUM_W'(fv_val) : (SUM_W'(fv_val) <<< 1);
   end

   always_ff @(posedge clock) begin
      if (prev_op_ff == DP_G_TAP) begin
         if (prev_tap_ff == TAP_FIRST) begin
            gx_acc_ff <= cx;
            gy_acc_ff <= cy;
            gt_acc_ff <= g_dif;
         end else begin
            gx_acc_ff <= gx_acc_ff + cx;
            gy_acc_ff <= gy_acc_ff + cy;
            gt_acc_ff <= gt_acc_ff + g_dif;
         end
      end
      if (prev_op_ff == DP_J_TAP) begin
         if (prev_tap_ff == TAP_FIRST) begin
            su_ff <= cu;
            sv_ff <= cv;
            gx_ff <= gx_q;
            gy_ff <= gy_q;
            gt_ff <= gt_q;
         end else begin
            su_ff <= su_ff + cu;
            sv_ff <= sv_ff + cv;
         end
      end
   end

   // neighbour average: rounded magnitude times the reciprocal of 12
   always_comb begin
      avg_src = (cmd.op == DP_BV_DIV) ? sv_ff : su_ff;
      avg_mag = avg_src[SUM_W-1] ? SUM_W'(-avg_src) : avg_src;
      avg_mag = avg_mag + SUM_W'(AVG_DIVISOR / 2);
      avg_q   = avg_prod_ff[AVG_SHIFT +: FLOW_W+1];
   end

   // multiply, denominator and numerator build-up
   always_comb begin
      m_a = MA_W'(gx_ff);
      m_b = NSUM_W'(gx_ff);
      case (cmd.op)
         DP_M_AA: begin
            m_a = $signed({1'b0, alpha_ff});
            m_b = $signed(NSUM_W'(alpha_ff));
         end
         DP_M_XX: m_b = NSUM_W'(gx_ff);
         DP_M_YY: begin
            m_a = MA_W'(gy_ff);
            m_b = NSUM_W'(gy_ff);
         end
         DP_M_XU: m_b = NSUM_W'(bu_ff);
         DP_M_YV: begin
            m_a = MA_W'(gy_ff);
            m_b = NSUM_W'(bv_ff);
         end
         DP_M_XN: m_b = nsum_ff;
         DP_M_YN: begin
            m_a = MA_W'(gy_ff);
            m_b = nsum_ff;
         end
         default: ;
      endcase
   end

   assign den_zero = den_ff == '0;

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = DEN_W'(1);
      case (cmd.op)
         DP_U_DIV, DP_V_DIV: begin
            div_start = 1'b1;
            div_num   = den_zero ? '0 : prod_ff;
            div_den   = den_zero ? DEN_W'(1) : den_ff;
         end
         default: ;
      endcase
   end

   hso_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_ff @(posedge clock) begin
      case (cmd.op)
         DP_M_AA, DP_M_XN, DP_M_YN: prod_ff <= m_a * m_b;
         DP_M_XX: begin
            prod_ff <= m_a * m_b;
            den_ff  <= DEN_W'(prod_ff);
         end
         DP_M_YY, DP_M_XU: begin
            prod_ff <= m_a * m_b;
            den_ff  <= den_ff + DEN_W'(prod_ff);
         end
         DP_M_YV: begin
            prod_ff <= m_a * m_b;
            nsum_ff <= NSUM_W'(prod_ff) + (NSUM_W'(gt_ff) <<< T_SHIFT);
         end
         DP_N_SUM: nsum_ff <= nsum_ff + NSUM_W'(prod_ff);
         DP_BU_DIV, DP_BV_DIV: begin
            avg_prod_ff <= AVG_PROD_W'(avg_mag) * AVG_PROD_W'(AVG_RECIP);
            avg_neg_ff  <= avg_src[SUM_W-1];
         end
         DP_BU_CAP: bu_ff <= avg_neg_ff ? -FLOW_W'(avg_q) : FLOW_W'(avg_q);
         DP_BV_CAP: bv_ff <= avg_neg_ff ? -FLOW_W'(avg_q) : FLOW_W'(avg_q);
         DP_U_CAP: nu_ff <= sat_flow(EXT_W'(bu_ff) - EXT_W'(div_quot));
         DP_V_CAP: nv_ff <= sat_flow(EXT_W'(bv_ff) - EXT_W'(div_quot));
         default: ;
      endcase
   end

   // walk, pass and result control
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_op_ff    <= DP_NONE;
         prev_tap_ff   <= TAP_FIRST;
         bank_ff       <= 1'b0;
         first_ff      <= 1'b1;
         flow_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         iter_ff       <= '0;
         iter_total_ff <= '0;
         w_ff          <= WW'(1);
         h_ff          <= HW'(1);
      end else begin
         prev_op_ff  <= cmd.op;
         prev_tap_ff <= cmd.tap;
         if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
         case (cmd.op)
            DP_START: begin
               w_ff          <= cur_w;
               h_ff          <= cur_h;
               i_ff          <= '0;
               j_ff          <= '0;
               k_ff          <= '0;
               bank_ff       <= 1'b0;
               first_ff      <= 1'b1;
               iter_ff       <= '0;
               iter_total_ff <= cfg.iteration_count;
               flow_count_ff <= (cfg.iteration_count != '0) ? cur_count : '0;
            end
            DP_G_WR, DP_J_WR: begin
               if (at_right) begin
                  i_ff <= '0;
                  if (at_bottom) begin
                     j_ff <= '0;
                     k_ff <= '0;
                     if (cmd.op == DP_J_WR) begin
                        bank_ff  <= ~bank_ff;
                        first_ff <= 1'b0;
                        iter_ff  <= iter_ff + 10'd1;
                     end
                  end else begin
                     j_ff <= j_ff + HW'(1);
                     k_ff <= k_ff + AW'(1);
                  end
               end else begin
                  i_ff <= i_ff + WW'(1);
                  k_ff <= k_ff + AW'(1);
               end
            end
            DP_RD_DONE, DP_FINISH: rsp_valid_ff <= 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_START) alpha_ff <= cfg.smoothness_alpha;
      if (cmd.op == DP_RD_ISSUE)
         rd_hit_ff <= (idx32 < 32'(cur_count)) && (idx32 < 32'(flow_count_ff));
      if (cmd.op == DP_RD_DONE) begin
         rsp_ff.result_kind <= RSP_FLOW;
         rsp_ff.flow_u      <= rd_hit_ff ? fu_q : '0;
         rsp_ff.flow_v      <= rd_hit_ff ? fv_q : '0;
      end else if (cmd.op == DP_FINISH) begin
         rsp_ff.result_kind <= RSP_DONE;
         rsp_ff.flow_u      <= '0;
         rsp_ff.flow_v      <= '0;
      end
   end

   assign status.rsp_full  = rsp_valid_ff;
   assign status.div_done  = div_done;
   assign status.last_pix  = at_right && at_bottom;
   assign status.last_iter = (11'(iter_ff) + 11'd1) == 11'(iter_total_ff);
   assign status.no_iter   = iter_total_ff == '0;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_data         = rsp_ff;

endmodule

@@ rtl/core/hso_ctrl.sv @@
// Controller: sequences loads, reads, the derivative sweep and the Jacobi passes.
// Talks to hso_dp through dp_cmd_type / dp_status_type; uses hso_pkg.
module hso_ctrl import hso_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_op,
   output logic          req_stall,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;
   logic [2:0]     tap_ff, tap_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         tap_ff   <= TAP_FIRST;
      end else begin
         state_ff <= state_in;
         tap_ff   <= tap_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      tap_in    = tap_ff;
      cmd.op    = DP_NONE;
      cmd.tap   = tap_ff;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = status.rsp_full && (req_op != OP_LOAD);
            if (req_valid && !req_stall) begin
               case (req_op)
                  OP_LOAD: cmd.op = DP_LOAD;
                  OP_COMPUTE: begin
                     cmd.op   = DP_START;
                     tap_in   = TAP_FIRST;
                     state_in = ST_G_TAP;
                  end
                  OP_READ: begin
                     cmd.op   = DP_RD_ISSUE;
                     state_in = ST_RD_DONE;
                  end
                  default: ;
               endcase
            end
         end
         ST_RD_DONE: begin
            cmd.op   = DP_RD_DONE;
            state_in = ST_IDLE;
         end
         ST_G_TAP: begin
            cmd.op = DP_G_TAP;
            tap_in = tap_ff + 3'd1;
            if (tap_ff == TAP_G_LAST) begin
               tap_in   = TAP_FIRST;
               state_in = ST_G_WAIT;
            end
         end
         ST_G_WAIT: state_in = ST_G_WR;
         ST_G_WR: begin
            cmd.op = DP_G_WR;
            if (!status.last_pix) state_in = ST_G_TAP;
            else if (status.no_iter) state_in = ST_DONE;
            else state_in = ST_J_TAP;
         end
         ST_J_TAP: begin
            cmd.op = DP_J_TAP;
            tap_in = tap_ff + 3'd1;
            if (tap_ff == TAP_J_LAST) begin
               tap_in   = TAP_FIRST;
               state_in = ST_J_WAIT;
            end
         end
         ST_J_WAIT: state_in = ST_BU_DIV;
         ST_BU_DIV: begin
            cmd.op   = DP_BU_DIV;
            state_in = ST_BU_WAIT;
         end
         ST_BU_WAIT: begin
            cmd.op   = DP_BU_CAP;
            state_in = ST_BV_DIV;
         end
         ST_BV_DIV: begin
            cmd.op   = DP_BV_DIV;
            state_in = ST_BV_WAIT;
         end
         ST_BV_WAIT: begin
            cmd.op   = DP_BV_CAP;
            state_in = ST_M_AA;
         end
         ST_M_AA: begin
            cmd.op   = DP_M_AA;
            state_in = ST_M_XX;
         end
         ST_M_XX: begin
            cmd.op   = DP_M_XX;
            state_in = ST_M_YY;
         end
         ST_M_YY: begin
            cmd.op   = DP_M_YY;
            state_in = ST_M_XU;
         end
         ST_M_XU: begin
            cmd.op   = DP_M_XU;
            state_in = ST_M_YV;
         end
         ST_M_YV: begin
            cmd.op   = DP_M_YV;
            state_in = ST_N_SUM;
         end
         ST_N_SUM: begin
            cmd.op   = DP_N_SUM;
            state_in = ST_M_XN;
         end
         ST_M_XN: begin
            cmd.op   = DP_M_XN;
            state_in = ST_U_DIV;
         end
         ST_U_DIV: begin
            cmd.op   = DP_U_DIV;
            state_in = ST_U_WAIT;
         end
         ST_U_WAIT: if (status.div_done) begin
            cmd.op   = DP_U_CAP;
            state_in = ST_M_YN;
         end
         ST_M_YN: begin
            cmd.op   = DP_M_YN;
            state_in = ST_V_DIV;
         end
         ST_V_DIV: begin
            cmd.op   = DP_V_DIV;
            state_in = ST_V_WAIT;
         end
         ST_V_WAIT: if (status.div_done) begin
            cmd.op   = DP_V_CAP;
            state_in = ST_J_WR;
         end
         ST_J_WR: begin
            cmd.op = DP_J_WR;
            if (status.last_pix && status.last_iter) state_in = ST_DONE;
            else state_in = ST_J_TAP;
         end
         ST_DONE: begin
            cmd.op   = DP_FINISH;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

`ifndef ASSERT_OFF
   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> req_stall)
      else $error("request taken while busy");
   a_finish_room: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DONE |-> !status.rsp_full)
      else $error("completion would overwrite a pending response");
   a_read_done: assert property (@(posedge clock) disable iff (reset)
      cmd.op == DP_RD_ISSUE |=> cmd.op == DP_RD_DONE)
      else $error("read issue not followed by read response");
   a_cap_on_done: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == DP_U_CAP || cmd.op == DP_V_CAP) |-> status.div_done)
      else $error("quotient captured before divider finished");
`endif

endmodule
